[design/assert_macros.svh]
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/sscs_pkg.sv]
`timescale 1ns / 1ps
package sscs_pkg;
    localparam int MaxSegments = 1024;
    localparam int AddrW = $clog2(MaxSegments);
    localparam int CntW = AddrW + 1;
    localparam int ValW = 31;
    localparam int ProdW = 2 * ValW;

    typedef enum logic [1:0] {
        ACT_LOAD_X = 2'd0,
        ACT_LOAD_Y = 2'd1,
        ACT_QUERY  = 2'd2,
        ACT_CLEAR  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_INCOMP = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_RD,
        S_INS_WAIT,
        S_INS_CMP,
        S_Q_RD,
        S_Q_WAIT,
        S_Q_M1,
        S_Q_M2,
        S_Q_M3,
        S_Q_CMP,
        S_DONE
    } t_state;
endpackage

[design/sscs_if.sv]
`timescale 1ns / 1ps
interface sscs_in_if;
    logic                     valid;
    logic                     ready;
    logic [1:0]               action;
    logic [sscs_pkg::ValW-1:0] value_x;
    logic [sscs_pkg::ValW-1:0] value_y;
    modport source (output valid, action, value_x, value_y, input ready);
    modport sink (input valid, action, value_x, value_y, output ready);
endinterface

interface sscs_out_if;
    logic                     valid;
    logic                     ready;
    logic [sscs_pkg::CntW-1:0] segments_crossed;
    logic [1:0]               status;
    modport source (output valid, segments_crossed, status, input ready);
    modport sink (input valid, segments_crossed, status, output ready);
endinterface

interface sscs_cfg_if;
    logic                     valid;
    logic                     ready;
    logic [sscs_pkg::CntW-1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[design/segment_side_count_search.sv]
`timescale 1ns / 1ps
// Load: each insert shift step runs INS_RD, INS_WAIT, INS_CMP; a read and a write port per store.
// Query: each binary-search probe runs Q_RD, Q_WAIT, Q_M1, Q_M2, Q_M3 and Q_CMP (one shared 31x31
// multiplier, three products); 11 probes at 1024 segments; status-only items go straight to done.
// One request at a time; result held in an output register until taken.
// Synchronous active-low reset clears counts, count register and control; stores are not cleared.
`include "assert_macros.svh"
module segment_side_count_search (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sscs_cfg_if.sink   cfg,
    sscs_in_if.sink    in_ch,
    sscs_out_if.source out_ch
);
    import sscs_pkg::*;

    logic [ValW-1:0] r_xmem [MaxSegments];
    logic [ValW-1:0] r_ymem [MaxSegments];

    t_state          r_state, n_state;
    logic [CntW-1:0] r_segcnt;
    logic [CntW-1:0] r_xl, r_yl;
    logic            r_isy;
    logic [ValW-1:0] r_vx, r_vy;
    logic [CntW-1:0] r_k, r_lo, r_hi;
    logic [ValW-1:0] r_rd_x, r_rd_y;
    logic [ProdW-1:0] r_prod, r_ab, r_sum;
    logic [CntW-1:0] r_res;
    logic [1:0]      r_stat;
    logic            r_ovalid;

    logic [CntW-1:0] w_n, w_mid;
    logic            w_acc, w_wr, w_gt;
    logic [AddrW-1:0] w_raddr, w_waddr;
    logic [ValW-1:0] w_wdata, w_ma, w_mb;
    logic [ProdW:0]  w_tot;

    assign w_n = (r_segcnt > CntW'(MaxSegments)) ? CntW'(MaxSegments) : r_segcnt;
    assign w_mid = CntW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    assign w_acc = in_ch.valid && in_ch.ready;
    assign w_tot = {1'b0, r_sum} + {1'b0, r_prod};
    assign w_gt = {1'b0, r_ab} > w_tot;

    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    assign cfg.ready = 1'b1;
    assign out_ch.valid = r_ovalid;
    assign out_ch.segments_crossed = r_res;
    assign out_ch.status = r_stat;

    always_comb begin
        w_raddr = (r_state inside {S_INS_RD, S_INS_WAIT, S_INS_CMP}) ?
                  AddrW'(r_k - CntW'(1)) : w_mid[AddrW-1:0];
        w_wr = 1'b0;
        w_waddr = r_k[AddrW-1:0];
        w_wdata = r_isy ? r_vy : r_vx;
        if (r_state == S_INS_CMP) begin
            w_wr = 1'b1;
            if ((r_isy ? r_rd_y : r_rd_x) > (r_isy ? r_vy : r_vx)) begin
                w_wdata = r_isy ? r_rd_y : r_rd_x;
            end
        end else if (r_state == S_INS_RD && r_k == '0) begin
            w_wr = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_x <= r_xmem[w_raddr];
        r_rd_y <= r_ymem[w_raddr];
        if (w_wr && !r_isy) r_xmem[w_waddr] <= w_wdata;
        if (w_wr && r_isy) r_ymem[w_waddr] <= w_wdata;
    end

    always_comb begin
        unique case (r_state)
            S_Q_M1:  begin w_ma = r_rd_x; w_mb = r_rd_y; end
            S_Q_M2:  begin w_ma = r_rd_x; w_mb = r_vy;   end
            default: begin w_ma = r_vx;   w_mb = r_rd_y; end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    unique case (t_action'(in_ch.action))
                        ACT_LOAD_X: n_state = (r_xl >= w_n) ? S_DONE : S_INS_RD;
                        ACT_LOAD_Y: n_state = (r_yl >= w_n) ? S_DONE : S_INS_RD;
                        ACT_QUERY: begin
                            if (r_xl < w_n || r_yl < w_n || w_n == '0) n_state = S_DONE;
                            else n_state = S_Q_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_INS_RD:   n_state = (r_k == '0) ? S_DONE : S_INS_WAIT;
            S_INS_WAIT: n_state = S_INS_CMP;
            S_INS_CMP: begin
                if ((r_isy ? r_rd_y : r_rd_x) > (r_isy ? r_vy : r_vx)) n_state = S_INS_RD;
                else n_state = S_DONE;
            end
            S_Q_RD:   n_state = S_Q_WAIT;
            S_Q_WAIT: n_state = S_Q_M1;
            S_Q_M1:   n_state = S_Q_M2;
            S_Q_M2:   n_state = S_Q_M3;
            S_Q_M3:   n_state = S_Q_CMP;
            S_Q_CMP:  n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (r_state == S_Q_CMP) begin
            if (w_gt) begin
                if (w_mid != r_lo) n_state = S_Q_RD;
            end else if (w_mid + CntW'(1) != r_hi) begin
                n_state = S_Q_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_segcnt <= '0;
            r_xl <= '0;
            r_yl <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg.valid && cfg.ready) r_segcnt <= cfg.data;
            if (out_ch.valid && out_ch.ready) r_ovalid <= 1'b0;
            if (r_state == S_DONE) r_ovalid <= 1'b1;
            if (r_state == S_IDLE && w_acc && in_ch.action == ACT_CLEAR) begin
                r_xl <= '0;
                r_yl <= '0;
            end
            if (w_wr && (r_state == S_INS_RD || n_state == S_DONE)) begin
                if (r_isy) r_yl <= r_yl + CntW'(1);
                else r_xl <= r_xl + CntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ProdW'(w_ma) * ProdW'(w_mb);
        unique case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_isy <= (in_ch.action == ACT_LOAD_Y);
                    r_vx <= in_ch.value_x;
                    r_vy <= in_ch.value_y;
                    r_lo <= '0;
                    r_hi <= w_n;
                    r_res <= '0;
                    r_k <= (in_ch.action == ACT_LOAD_Y) ? r_yl : r_xl;
                    r_stat <= ST_OK;
                    if (in_ch.action == ACT_LOAD_X && r_xl >= w_n) r_stat <= ST_FULL;
                    if (in_ch.action == ACT_LOAD_Y && r_yl >= w_n) r_stat <= ST_FULL;
                    if (in_ch.action == ACT_QUERY && (r_xl < w_n || r_yl < w_n))
                        r_stat <= ST_INCOMP;
                end
            end
            S_INS_CMP: begin
                if ((r_isy ? r_rd_y : r_rd_x) > (r_isy ? r_vy : r_vx)) r_k <= r_k - CntW'(1);
            end
            S_Q_M2: r_ab <= r_prod;
            S_Q_M3: r_sum <= r_prod;
            S_Q_CMP: begin
                if (w_gt) begin
                    r_hi <= w_mid;
                    r_res <= r_lo;
                end else begin
                    r_lo <= w_mid + CntW'(1);
                    r_res <= w_mid + CntW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    `ASSERT_NEVER(a_ready_busy, i_clk, i_rst_n, in_ch.ready && r_state != S_IDLE, "ready while busy")
    `ASSERT_NEVER(a_xl_bound, i_clk, i_rst_n, r_xl > CntW'(MaxSegments), "x count overflow")
    `ASSERT_CLK(a_done_valid, i_clk, i_rst_n, r_state == S_DONE |=> out_ch.valid, "no result")
    `ASSERT_NEVER(a_search, i_clk, i_rst_n, r_state == S_Q_RD && r_lo >= r_hi, "empty search")
endmodule

[tb/segment_side_count_search_test.sv]
`timescale 1ns / 1ps
module segment_side_count_search_test;
    import sscs_pkg::*;

    localparam logic [ValW-1:0] VMAX = {ValW{1'b1}};
    localparam int unsigned CNT_MAX = (1 << CntW) - 1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    always #1 i_clk = ~i_clk;

    sscs_cfg_if cfg_if ();
    sscs_in_if  in_if ();
    sscs_out_if out_if ();

    segment_side_count_search u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .cfg     (cfg_if),
        .in_ch   (in_if),
        .out_ch  (out_if)
    );

    // mirror of the block state
    logic [ValW-1:0] x_sorted [MaxSegments];
    logic [ValW-1:0] y_sorted [MaxSegments];
    int unsigned     x_held, y_held, seg_count;

    typedef struct packed {
        logic [CntW-1:0] crossed;
        t_status         status;
    } t_answer;

    t_answer answer_q[$];
    int      fail_count = 0;
    int      n_answered = 0, n_full = 0, n_incomp = 0, n_requests = 0;

    // typed expectation for the request currently on the input channel
    logic    typed_en = 1'b0;
    t_answer typed_ans;

    function automatic int unsigned active_n();
        return (seg_count > MaxSegments) ? MaxSegments : seg_count;
    endfunction

    function automatic t_status sorted_store_insert(ref logic [ValW-1:0] store [MaxSegments],
                                                    ref int unsigned held,
                                                    input logic [ValW-1:0] v);
        int unsigned k;
        k = held;
        if (k >= active_n()) return ST_FULL;
        while (k > 0 && store[k-1] > v) begin
            store[k] = store[k-1];
            k--;
        end
        store[k] = v;
        held++;
        return ST_OK;
    endfunction

    function automatic t_answer count_crossed(t_action act, logic [ValW-1:0] vx,
                                              logic [ValW-1:0] vy);
        t_answer r;
        int unsigned n, lo, hi, mid;
        longint unsigned a, b;
        r.crossed = '0;
        r.status  = ST_OK;
        case (act)
            ACT_LOAD_X: r.status = sorted_store_insert(x_sorted, x_held, vx);
            ACT_LOAD_Y: r.status = sorted_store_insert(y_sorted, y_held, vy);
            ACT_QUERY: begin
                n = active_n();
                if (x_held < n || y_held < n) begin
                    r.status = ST_INCOMP;
                end else begin
                    lo = 0;
                    hi = n;
                    while (hi > lo) begin
                        mid = (lo + hi) / 2;
                        a = x_sorted[mid];
                        b = y_sorted[mid];
                        if (a * b > a * longint'(vy) + longint'(vx) * b) hi = mid;
                        else lo = mid + 1;
                    end
                    r.crossed = lo[CntW-1:0];
                end
            end
            default: begin
                x_held = 0;
                y_held = 0;
            end
        endcase
        return r;
    endfunction

    // request and result monitors
    always @(posedge i_clk) begin
        t_answer p, got, want;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            p = count_crossed(t_action'(in_if.action), in_if.value_x, in_if.value_y);
            if (typed_en) begin
                if (p !== typed_ans) begin
                    $display("%0t: predictor disagrees with table: expected %0d/%0d, got %0d/%0d",
                             $time, typed_ans.crossed, typed_ans.status, p.crossed, p.status);
                    fail_count++;
                end
                p = typed_ans;
            end
            answer_q.push_back(p);
            n_requests++;
            if (p.status == ST_FULL) n_full++;
            else if (p.status == ST_INCOMP) n_incomp++;
            else if (in_if.action == ACT_QUERY) n_answered++;
        end
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.crossed = out_if.segments_crossed;
            got.status  = t_status'(out_if.status);
            if (answer_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %0d/%0d",
                         $time, got.crossed, got.status);
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                if (got.crossed !== want.crossed) begin
                    $display("%0t: segments_crossed mismatch: expected %0d, actual %0d",
                             $time, want.crossed, got.crossed);
                    fail_count++;
                end
                if (got.status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, got.status);
                    fail_count++;
                end
            end
        end
    end

    // result side stalls
    logic sink_burst = 1'b0;
    initial begin
        int w;
        out_if.ready <= 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            w = sink_burst ? 0 : $urandom_range(0, 6);
            if (w > 0) begin
                out_if.ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            out_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(out_if.valid && out_if.ready));
            if ($urandom_range(0, 99) < 3) sink_burst = ~sink_burst;
        end
    end

    logic src_burst = 1'b0;

    task automatic send_request(t_action act, logic [ValW-1:0] vx, logic [ValW-1:0] vy);
        int w;
        w = src_burst ? 0 : $urandom_range(0, 6);
        if (w > 0) begin
            in_if.valid <= 1'b0;
            repeat (w) @(posedge i_clk);
        end
        in_if.valid   <= 1'b1;
        in_if.action  <= act;
        in_if.value_x <= vx;
        in_if.value_y <= vy;
        do @(posedge i_clk); while (!in_if.ready);
        if ($urandom_range(0, 99) < 3) src_burst = ~src_burst;
    endtask

    task automatic drain();
        in_if.valid <= 1'b0;
        typed_en <= 1'b0;
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_count(int unsigned n);
        drain();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= n[CntW-1:0];
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        seg_count = n;
    endtask

    function automatic logic [ValW-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return VMAX;
            2, 3: return ValW'($urandom_range(0, 100));
            4, 5: return ValW'($urandom_range(0, 100000));
            default: return ValW'($urandom);
        endcase
    endfunction

    typedef struct {
        logic            set_cnt;
        int unsigned     cnt;
        t_action         act;
        logic [ValW-1:0] vx;
        logic [ValW-1:0] vy;
        logic            typed;
        logic [CntW-1:0] crossed;
        t_status         status;
    } t_row;

    t_row directed [] = '{
        '{1'b0, 0, ACT_QUERY,  '0,   '0,   1'b1, '0, ST_OK},
        '{1'b0, 0, ACT_LOAD_X, VMAX, '0,   1'b1, '0, ST_FULL},
        '{1'b0, 0, ACT_LOAD_Y, '0,   VMAX, 1'b1, '0, ST_FULL},
        '{1'b0, 0, ACT_CLEAR,  VMAX, VMAX, 1'b1, '0, ST_OK},
        '{1'b1, 3, ACT_QUERY,  5,    5,    1'b1, '0, ST_INCOMP},
        '{1'b0, 0, ACT_LOAD_X, VMAX, 0,    1'b1, '0, ST_OK},
        '{1'b0, 0, ACT_LOAD_X, 0,    VMAX, 1'b1, '0, ST_OK},
        '{1'b0, 0, ACT_LOAD_Y, 9,    0,    1'b1, '0, ST_OK},
        '{1'b0, 0, ACT_QUERY,  1,    1,    1'b1, '0, ST_INCOMP},
        '{1'b0, 0, ACT_LOAD_X, 0,    0,    1'b1, '0, ST_OK},
        '{1'b0, 0, ACT_LOAD_X, 4,    0,    1'b1, '0, ST_FULL},
        '{1'b0, 0, ACT_LOAD_Y, 0,    VMAX, 1'b1, '0, ST_OK},
        '{1'b0, 0, ACT_LOAD_Y, 0,    VMAX, 1'b1, '0, ST_OK},
        '{1'b0, 0, ACT_QUERY,  0,    0,    1'b0, '0, ST_OK},
        '{1'b0, 0, ACT_QUERY,  VMAX, VMAX, 1'b0, '0, ST_OK},
        '{1'b0, 0, ACT_QUERY,  1000, 1000, 1'b0, '0, ST_OK},
        '{1'b0, 0, ACT_QUERY,  0,    VMAX, 1'b0, '0, ST_OK},
        '{1'b1, 2, ACT_QUERY,  VMAX, 0,    1'b0, '0, ST_OK},
        '{1'b0, 0, ACT_QUERY,  3,    3,    1'b0, '0, ST_OK},
        '{1'b1, CNT_MAX, ACT_QUERY, 1, 1,  1'b1, '0, ST_INCOMP},
        '{1'b0, 0, ACT_CLEAR,  0,    0,    1'b1, '0, ST_OK},
        '{1'b1, 1, ACT_QUERY,  0,    0,    1'b1, '0, ST_INCOMP}
    };

    initial begin
        int unsigned n, q;
        logic [ValW-1:0] base;
        i_rst_n       <= 1'b0;
        in_if.valid   <= 1'b0;
        in_if.action  <= ACT_CLEAR;
        in_if.value_x <= '0;
        in_if.value_y <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.data   <= '0;
        x_held = 0;
        y_held = 0;
        seg_count = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            if (directed[i].set_cnt) write_count(directed[i].cnt);
            typed_en  <= directed[i].typed;
            typed_ans <= '{directed[i].crossed, directed[i].status};
            send_request(directed[i].act, directed[i].vx, directed[i].vy);
        end
        drain();

        // one large set, loaded in ascending order to keep inserts short
        write_count(MaxSegments / 8);
        send_request(ACT_CLEAR, '0, '0);
        for (int i = 0; i < MaxSegments / 8; i++) begin
            base = ValW'(i * 2000000 + $urandom_range(0, 1999999));
            send_request(ACT_LOAD_X, base, rand_value());
            base = ValW'(i * 2000000 + $urandom_range(0, 1999999));
            send_request(ACT_LOAD_Y, rand_value(), base);
        end
        send_request(ACT_LOAD_X, VMAX, '0);
        for (int i = 0; i < 8; i++) send_request(ACT_QUERY, rand_value(), rand_value());
        write_count(CNT_MAX);
        for (int i = 0; i < 4; i++) send_request(ACT_QUERY, rand_value(), rand_value());
        write_count(5);
        for (int i = 0; i < 4; i++) send_request(ACT_QUERY, rand_value(), rand_value());

        // random data sets, mostly well formed
        while (n_requests < 600) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
            write_count(n);
            if ($urandom_range(0, 3) != 0) send_request(ACT_CLEAR, rand_value(), rand_value());
            while (x_held < active_n() || y_held < active_n() || in_if.valid) begin
                if ($urandom_range(0, 9) == 0)
                    send_request(t_action'($urandom_range(0, 3) == 0 ? ACT_CLEAR : ACT_QUERY),
                                 rand_value(), rand_value());
                else if (x_held < active_n() && (y_held >= active_n() || $urandom_range(0, 1)))
                    send_request(ACT_LOAD_X, rand_value(), rand_value());
                else if (y_held < active_n())
                    send_request(ACT_LOAD_Y, rand_value(), rand_value());
                drain();
            end
            q = $urandom_range(4, 14);
            for (int i = 0; i < q; i++) begin
                case ($urandom_range(0, 9))
                    0: send_request(ACT_LOAD_X, rand_value(), rand_value());
                    1: send_request(ACT_LOAD_Y, rand_value(), rand_value());
                    default: send_request(ACT_QUERY, rand_value(), rand_value());
                endcase
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("Covered %0d requests: %0d answered queries, %0d full-store loads,",
                 n_requests, n_answered, n_full);
        $display("%0d early queries, segment counts from 0 up to %0d.", n_incomp, CNT_MAX);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Simulation FAILED");
        $finish;
    end
endmodule

[filelist.f]
+incdir+design
design/sscs_pkg.sv
design/sscs_if.sv
design/segment_side_count_search.sv
tb/segment_side_count_search_test.sv
